// File: hdl/pbms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbms_pkg
// Shared types and constants for the positional bigram statistics block.
// ----------------------------------------------------------------------------
package pbms_pkg;

  localparam int MAX_LEN    = 16;
  localparam int CHARSET    = 256;
  localparam int COUNT_BITS = 32;

  localparam int POS_W   = 4;
  localparam int CODE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int CELL_AW = POS_W + 2 * CODE_W;
  localparam int ROW_AW  = POS_W + CODE_W;
  localparam int TOTAL_W = 40;
  localparam int PROB_W  = 16;
  localparam int LINE_W  = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [LEN_W-1:0] MIN_LENGTH_RST = LEN_W'(1);
  localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(16);

  typedef enum logic [1:0] {
    ACT_CHAR  = 2'd0,
    ACT_EOL   = 2'd1,
    ACT_FINAL = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// File: hdl/pbms_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbms_req_if
// Input item channel: action plus character and lookup fields.
// ----------------------------------------------------------------------------
interface pbms_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;
  logic [3:0] position;
  logic [7:0] prev_code;
  logic [7:0] next_code;

  modport source (output valid, action, char_code, position, prev_code, next_code,
                  input ready);
  modport sink (input valid, action, char_code, position, prev_code, next_code,
                output ready);
endinterface
`default_nettype wire

// File: hdl/pbms_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbms_rsp_if
// Result channel: one result per input item.
// ----------------------------------------------------------------------------
interface pbms_rsp_if;
  logic        valid;
  logic        ready;
  logic        line_accepted;
  logic [31:0] total_lines;
  logic [31:0] valid_lines;
  logic [31:0] adjusted_count;
  logic [15:0] probability;
  logic        not_finalized;

  modport source (output valid, line_accepted, total_lines, valid_lines, adjusted_count,
                  probability, not_finalized, input ready);
  modport sink (input valid, line_accepted, total_lines, valid_lines, adjusted_count,
                probability, not_finalized, output ready);
endinterface
`default_nettype wire

// File: hdl/pbms_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbms_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pbms_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/pbms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbms_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pbms_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/pbms_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbms_div
// Bit-serial divider: floor(count * 65535 / total), count <= total.
// ----------------------------------------------------------------------------
module pbms_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [pbms_pkg::COUNT_BITS-1:0]  count,
  input  wire logic [pbms_pkg::TOTAL_W-1:0]     total,
  output logic                                  done,
  output logic      [pbms_pkg::PROB_W-1:0]      quotient
);
  import pbms_pkg::*;

  localparam int NUM_W = COUNT_BITS + PROB_W;
  localparam int REM_W = TOTAL_W + 1;
  localparam int CNT_W = $clog2(PROB_W);

  logic                 busy;
  logic [CNT_W-1:0]     cnt;
  logic [REM_W-1:0]     rem;
  logic [PROB_W-1:0]    num_lo;
  logic [TOTAL_W-1:0]   den;
  logic [NUM_W-1:0]     num;
  logic [REM_W-1:0]     shifted;
  logic                 fits;

  // count * 65535 as (count << 16) - count
  assign num     = {count, PROB_W'(0)} - NUM_W'(count);
  assign shifted = {rem[REM_W-2:0], num_lo[PROB_W-1]};
  assign fits    = shifted >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(PROB_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= REM_W'(num[NUM_W-1:PROB_W]);
      num_lo   <= num[PROB_W-1:0];
      den      <= total;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? shifted - {1'b0, den} : shifted;
      num_lo   <= {num_lo[PROB_W-2:0], 1'b0};
      quotient <= {quotient[PROB_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// File: hdl/positional_bigram_markov_stats.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_bigram_markov_stats
// Per-position byte-bigram counter with finalize and probability readout.
// ----------------------------------------------------------------------------
// Channels: req takes one item per transaction (character, end of line,
// finalize, read); rsp returns exactly one result per item; cfg writes
// min_length (index 0) and max_length (index 1) and is always ready.
// Counts live in a 1M x 32 cell RAM with letter, rank and row-total RAMs
// beside it; every update is a read-modify-write of one entry.
// Steps per item, from accept to result load:
//   a character or a read before finalize loads its result directly; a
//   read after finalize may run the 16-step divider; a counted end of line
//   reads and writes back the cell and letter counters for each byte, a
//   rejected one loads its result directly; finalize does a rank scan
//   and then a streamed cell adjust.
// Reset: after rst drops the block clears the cell and letter RAMs, one
// entry a cycle, and takes no item until the clear is done.
// The result sits in an output register; when rsp stalls the block holds
// the finished result and waits before taking the next item.
// ----------------------------------------------------------------------------
module positional_bigram_markov_stats (
  input  wire logic clk,
  input  wire logic rst,
  pbms_req_if.sink  req,
  pbms_rsp_if.source rsp,
  pbms_cfg_if.sink  cfg
);
  import pbms_pkg::*;

  localparam int CLR_W = CELL_AW + 1;
  localparam int ABC_W = CODE_W + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [LINE_W-1:0]     LINE_MAX = '1;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_EOL_RD, S_EOL_WR, S_FR_LOAD, S_FR_CAP, S_FR_SCAN,
    S_FA, S_RD_CAP, S_DIV, S_RESP
  } state_t;

  state_t state;

  logic [CLR_W-1:0]      clr_addr;
  logic [LEN_W-1:0]      min_len, max_len;
  logic [CODE_W-1:0]     line_store [MAX_LEN];
  logic [LEN_W-1:0]      line_len, eol_len, step;
  logic                  line_ovf;
  logic [LINE_W-1:0]     lines_seen, lines_counted;
  logic                  finalized;
  logic [CODE_W-1:0]     prev_byte;
  logic [CELL_AW-1:0]    eol_taddr;
  logic [CODE_W-1:0]     eol_laddr;
  logic [ABC_W-1:0]      a_idx, b_cnt;
  logic [COUNT_BITS-1:0] ca;
  logic                  b_v;
  logic [CODE_W-1:0]     b_idx, rank_acc;
  logic [CLR_W-1:0]      c_idx;
  logic                  a_v;
  logic [CELL_AW-1:0]    a_addr;
  logic [TOTAL_W-1:0]    row_total;
  logic                  r_acc, r_nf;
  logic [COUNT_BITS-1:0] r_count;
  logic [PROB_W-1:0]     r_prob;

  logic                  o_valid, o_acc, o_nf;
  logic [LINE_W-1:0]     o_total, o_valid_lines;
  logic [COUNT_BITS-1:0] o_count;
  logic [PROB_W-1:0]     o_prob;

  // RAM ports
  logic                  t_we, l_we, k_we, g_we;
  logic [CELL_AW-1:0]    t_waddr, t_raddr;
  logic [COUNT_BITS-1:0] t_wdata, t_rdata;
  logic [CODE_W-1:0]     l_waddr, l_raddr;
  logic [COUNT_BITS-1:0] l_wdata, l_rdata;
  logic [CODE_W-1:0]     k_waddr, k_raddr;
  logic [CODE_W-1:0]     k_wdata, k_rdata;
  logic [ROW_AW-1:0]     g_waddr, g_raddr;
  logic [TOTAL_W-1:0]    g_wdata, g_rdata;

  logic                  div_start, div_done;
  logic [PROB_W-1:0]     div_q;

  logic [CODE_W-1:0]     cur_byte;
  logic [CELL_AW-1:0]    eol_cell;
  logic [LEN_W-1:0]      hi_len;
  logic                  line_ok;
  logic [COUNT_BITS:0]   adj_sum;
  logic [COUNT_BITS-1:0] adj_add, adj_val;
  logic [TOTAL_W-1:0]    tot_sum;
  logic                  b_ahead;
  logic                  rsp_free;

  pbms_ram #(.ADDR_W(CELL_AW), .DATA_W(COUNT_BITS)) u_cells (
    .clk, .we(t_we), .waddr(t_waddr), .wdata(t_wdata), .raddr(t_raddr), .rdata(t_rdata)
  );
  pbms_ram #(.ADDR_W(CODE_W), .DATA_W(COUNT_BITS)) u_letters (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );
  pbms_ram #(.ADDR_W(CODE_W), .DATA_W(CODE_W)) u_ranks (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata)
  );
  pbms_ram #(.ADDR_W(ROW_AW), .DATA_W(TOTAL_W)) u_totals (
    .clk, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
  );

  pbms_div u_div (
    .clk, .rst, .start(div_start), .count(t_rdata), .total(g_rdata),
    .done(div_done), .quotient(div_q)
  );

  assign cur_byte = line_store[step[POS_W-1:0]];
  assign eol_cell = (step == '0) ? CELL_AW'(cur_byte)
                                 : {step[POS_W-1:0] - 1'b1, prev_byte, cur_byte};
  assign hi_len   = (max_len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : max_len;
  assign line_ok  = !finalized && !line_ovf && (line_len != '0) &&
                    (line_len >= min_len) && (line_len <= hi_len);

  // finalize adjustment: nonzero cells gain CHARSET, zero cells gain
  // CHARSET-1 minus the column letter's rank
  assign adj_add = (t_rdata != '0) ? COUNT_BITS'(CHARSET)
                                   : COUNT_BITS'(CHARSET - 1) - COUNT_BITS'(k_rdata);
  assign adj_sum = {1'b0, t_rdata} + {1'b0, adj_add};
  assign adj_val = adj_sum[COUNT_BITS] ? CNT_MAX : adj_sum[COUNT_BITS-1:0];
  assign tot_sum = ((a_addr[CODE_W-1:0] == '0) ? '0 : row_total) + TOTAL_W'(adj_val);

  assign b_ahead  = (l_rdata > ca) || ((l_rdata == ca) && (b_idx < a_idx[CODE_W-1:0]));
  assign rsp_free = !o_valid || rsp.ready;
  assign div_start = (state == S_RD_CAP) && finalized && (g_rdata != '0) &&
                     (TOTAL_W'(t_rdata) <= g_rdata);

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    t_we = 1'b0;  t_waddr = '0;  t_wdata = '0;
    l_we = 1'b0;  l_waddr = '0;  l_wdata = '0;
    k_we = 1'b0;  k_waddr = a_idx[CODE_W-1:0];  k_wdata = rank_acc;
    g_we = 1'b0;  g_waddr = a_addr[CELL_AW-1:CODE_W];  g_wdata = tot_sum;
    t_raddr = {req.position, req.prev_code, req.next_code};
    g_raddr = {req.position, req.prev_code};
    l_raddr = '0;
    k_raddr = c_idx[CODE_W-1:0];
    unique case (state)
      S_CLR: begin
        t_we    = 1'b1;
        t_waddr = clr_addr[CELL_AW-1:0];
        l_we    = (clr_addr < CLR_W'(CHARSET));
        l_waddr = clr_addr[CODE_W-1:0];
      end
      S_EOL_RD: begin
        t_raddr = eol_cell;
        l_raddr = cur_byte;
      end
      S_EOL_WR: begin
        t_we    = 1'b1;
        t_waddr = eol_taddr;
        t_wdata = (t_rdata == CNT_MAX) ? t_rdata : t_rdata + 1'b1;
        l_we    = 1'b1;
        l_waddr = eol_laddr;
        l_wdata = (l_rdata == CNT_MAX) ? l_rdata : l_rdata + 1'b1;
      end
      S_FR_LOAD: l_raddr = a_idx[CODE_W-1:0];
      S_FR_SCAN: begin
        l_raddr = b_cnt[CODE_W-1:0];
        k_we    = (b_cnt == ABC_W'(CHARSET)) && !b_v;
      end
      S_FA: begin
        t_raddr = c_idx[CELL_AW-1:0];
        t_we    = a_v;
        t_waddr = a_addr;
        t_wdata = adj_val;
        g_we    = a_v && (a_addr[CODE_W-1:0] == '1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && req.valid && (req.action == ACT_CHAR) &&
        (line_len < LEN_W'(MAX_LEN))) begin
      line_store[line_len[POS_W-1:0]] <= req.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_addr      <= '0;
      min_len       <= MIN_LENGTH_RST;
      max_len       <= MAX_LENGTH_RST;
      line_len      <= '0;
      line_ovf      <= 1'b0;
      lines_seen    <= '0;
      lines_counted <= '0;
      finalized     <= 1'b0;
      o_valid       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == REG_MIN_LENGTH) min_len <= cfg.data;
        if (cfg.index == REG_MAX_LENGTH) max_len <= cfg.data;
      end
      if (rsp.ready && !((state == S_RESP) && rsp_free)) o_valid <= 1'b0;

      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CLR_W'(2**CELL_AW - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            r_acc   <= (req.action == ACT_EOL) && line_ok;
            r_nf    <= (req.action == ACT_READ) && !finalized;
            r_count <= '0;
            r_prob  <= '0;
            unique case (req.action)
              ACT_CHAR: begin
                if (line_len < LEN_W'(MAX_LEN)) line_len <= line_len + 1'b1;
                else line_ovf <= 1'b1;
                state <= S_RESP;
              end
              ACT_EOL: begin
                if (lines_seen != LINE_MAX) lines_seen <= lines_seen + 1'b1;
                line_len <= '0;
                line_ovf <= 1'b0;
                eol_len  <= line_len;
                step     <= '0;
                if (line_ok) begin
                  if (lines_counted != LINE_MAX) lines_counted <= lines_counted + 1'b1;
                  state <= S_EOL_RD;
                end else begin
                  state <= S_RESP;
                end
              end
              ACT_FINAL: begin
                a_idx <= '0;
                state <= finalized ? S_RESP : S_FR_LOAD;
              end
              ACT_READ: begin
                state <= S_RD_CAP;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_EOL_RD: begin
          if (step == eol_len) begin
            state <= S_RESP;
          end else begin
            eol_taddr <= eol_cell;
            eol_laddr <= cur_byte;
            prev_byte <= cur_byte;
            step      <= step + 1'b1;
            state     <= S_EOL_WR;
          end
        end
        S_EOL_WR: state <= S_EOL_RD;
        S_FR_LOAD: begin
          if (a_idx == ABC_W'(CHARSET)) begin
            c_idx <= '0;
            a_v   <= 1'b0;
            state <= S_FA;
          end else begin
            state <= S_FR_CAP;
          end
        end
        S_FR_CAP: begin
          ca       <= l_rdata;
          b_cnt    <= '0;
          b_v      <= 1'b0;
          rank_acc <= '0;
          state    <= S_FR_SCAN;
        end
        S_FR_SCAN: begin
          b_v   <= (b_cnt != ABC_W'(CHARSET));
          b_idx <= b_cnt[CODE_W-1:0];
          if (b_cnt != ABC_W'(CHARSET)) b_cnt <= b_cnt + 1'b1;
          if (b_v && b_ahead) rank_acc <= rank_acc + 1'b1;
          if ((b_cnt == ABC_W'(CHARSET)) && !b_v) begin
            a_idx <= a_idx + 1'b1;
            state <= S_FR_LOAD;
          end
        end
        S_FA: begin
          a_v    <= !c_idx[CELL_AW];
          a_addr <= c_idx[CELL_AW-1:0];
          if (!c_idx[CELL_AW]) c_idx <= c_idx + 1'b1;
          if (a_v) row_total <= tot_sum;
          if (c_idx[CELL_AW] && !a_v) begin
            finalized <= 1'b1;
            state     <= S_RESP;
          end
        end
        S_RD_CAP: begin
          r_count <= t_rdata;
          state   <= div_start ? S_DIV : S_RESP;
        end
        S_DIV: begin
          if (div_done) begin
            r_prob <= div_q;
            state  <= S_RESP;
          end
        end
        S_RESP: begin
          if (rsp_free) begin
            o_valid       <= 1'b1;
            o_acc         <= r_acc;
            o_total       <= lines_seen;
            o_valid_lines <= lines_counted;
            o_count       <= r_count;
            o_prob        <= r_prob;
            o_nf          <= r_nf;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.line_accepted  = o_acc;
  assign rsp.total_lines    = o_total;
  assign rsp.valid_lines    = o_valid_lines;
  assign rsp.adjusted_count = o_count;
  assign rsp.probability    = o_prob;
  assign rsp.not_finalized  = o_nf;

  a_counted_le_seen: assert property (@(posedge clk) disable iff (rst)
    lines_counted <= lines_seen) else $error("more lines counted than seen");

  a_nf_prob_zero: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_nf) |-> (o_prob == '0)) else $error("probability before finalize");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> clr_addr[CELL_AW]) else $error("item taken during clear");

  a_adjust_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_FA) |-> !finalized) else $error("cell adjust after finalize");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional bigram statistics block: lines of
// characters are streamed in with random gaps and output stalls, and every
// result is compared with a local model of the counters and finalize math.
// ----------------------------------------------------------------------------
module tb;
  import pbms_pkg::*;

  typedef struct packed {
    logic        line_accepted;
    logic [31:0] total_lines;
    logic [31:0] valid_lines;
    logic [31:0] adjusted_count;
    logic [15:0] probability;
    logic        not_finalized;
  } stats_rsp_t;

  class bigram_scoreboard;
    int unsigned        cell_cnt[int];
    longint unsigned    row_sum[int];
    int unsigned        letter_cnt[256];
    int unsigned        rank[256];
    logic [7:0]         line_buf[MAX_LEN];
    int unsigned        line_len;
    bit                 overflow;
    int unsigned        seen, counted;
    bit                 frozen;
    int unsigned        min_len = 1, max_len = 16;
    stats_rsp_t         pending_q[$];
    int                 errors;

    function void set_reg(reg_idx_t idx, logic [4:0] val);
      if (idx == REG_MIN_LENGTH) min_len = val;
      else max_len = val;
    endfunction

    function int key(int p, int r, int c);
      return (p << 16) | (r << 8) | c;
    endfunction

    function void bump(int k);
      if (!cell_cnt.exists(k)) cell_cnt[k] = 0;
      if (cell_cnt[k] != 32'hFFFF_FFFF) cell_cnt[k]++;
    endfunction

    function int unsigned cell_value(int p, int r, int c);
      int unsigned raw;
      longint unsigned adj;
      raw = cell_cnt.exists(key(p, r, c)) ? cell_cnt[key(p, r, c)] : 0;
      if (!frozen) return raw;
      adj = raw + ((raw != 0) ? 256 : (255 - rank[c]));
      return (adj > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : adj[31:0];
    endfunction

    function longint unsigned row_total(int p, int r);
      longint unsigned t;
      t = 0;
      if (row_sum.exists((p << 8) | r)) return row_sum[(p << 8) | r];
      for (int j = 0; j < 256; j++) t += cell_value(p, r, j);
      row_sum[(p << 8) | r] = t;
      return t;
    endfunction

    function void finish_line(output logic ok);
      int unsigned hi;
      if (seen != 32'hFFFF_FFFF) seen++;
      hi = (max_len > MAX_LEN) ? MAX_LEN : max_len;
      ok = !frozen && !overflow && line_len >= 1 && line_len >= min_len && line_len <= hi;
      if (ok) begin
        if (counted != 32'hFFFF_FFFF) counted++;
        bump(key(0, 0, line_buf[0]));
        for (int p = 0; p < line_len; p++) begin
          if (letter_cnt[line_buf[p]] != 32'hFFFF_FFFF) letter_cnt[line_buf[p]]++;
          if (p + 1 < line_len) bump(key(p, line_buf[p], line_buf[p+1]));
        end
      end
      line_len = 0;
      overflow = 0;
    endfunction

    function void freeze();
      if (frozen) return;
      frozen = 1;
      foreach (rank[a]) begin
        rank[a] = 0;
        for (int b = 0; b < 256; b++)
          if (letter_cnt[b] > letter_cnt[a] || (letter_cnt[b] == letter_cnt[a] && b < a))
            rank[a]++;
      end
    endfunction

    // accepted input transaction: advance the model, queue the result
    function void note_input(action_t act, logic [7:0] ch, logic [3:0] pos,
                             logic [7:0] prv, logic [7:0] nxt);
      stats_rsp_t r;
      logic ok;
      longint unsigned tot;
      logic [79:0] num;
      r = '0;
      case (act)
        ACT_CHAR: begin
          if (line_len < MAX_LEN) begin
            line_buf[line_len] = ch;
            line_len++;
          end else overflow = 1;
        end
        ACT_EOL: begin
          finish_line(ok);
          r.line_accepted = ok;
        end
        ACT_FINAL: freeze();
        default: begin
          r.not_finalized = !frozen;
          r.adjusted_count = cell_value(pos, prv, nxt);
          if (frozen) begin
            tot = row_total(pos, prv);
            if (tot != 0 && r.adjusted_count <= tot) begin
              num = 80'(r.adjusted_count) * 80'd65535 / 80'(tot);
              r.probability = num[15:0];
            end
          end
        end
      endcase
      r.total_lines = seen;
      r.valid_lines = counted;
      pending_q.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(stats_rsp_t got);
      stats_rsp_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      w = pending_q.pop_front();
      if (got.line_accepted !== w.line_accepted)
        report("line_accepted", got.line_accepted, w.line_accepted);
      if (got.total_lines !== w.total_lines)
        report("total_lines", got.total_lines, w.total_lines);
      if (got.valid_lines !== w.valid_lines)
        report("valid_lines", got.valid_lines, w.valid_lines);
      if (got.adjusted_count !== w.adjusted_count)
        report("adjusted_count", got.adjusted_count, w.adjusted_count);
      if (got.probability !== w.probability)
        report("probability", got.probability, w.probability);
      if (got.not_finalized !== w.not_finalized)
        report("not_finalized", got.not_finalized, w.not_finalized);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;

  pbms_req_if req ();
  pbms_rsp_if rsp ();
  pbms_cfg_if cfg ();

  positional_bigram_markov_stats DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  bigram_scoreboard sb = new();
  bit quiet;          // no-idle stretch on both sides
  int hold_request;   // cycles the receiver should stall
  int stall_left;
  int idle_cycles;
  logic [7:0] recent[$];

  initial begin
    req.valid = 0; req.action = ACT_CHAR; req.char_code = 0;
    req.position = 0; req.prev_code = 0; req.next_code = 0;
    cfg.valid = 0; cfg.index = REG_MIN_LENGTH; cfg.data = 0;
    rsp.ready = 0;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp.ready = 0;
    end else if (quiet) rsp.ready = 1;
    else rsp.ready = ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result({rsp.line_accepted, rsp.total_lines, rsp.valid_lines,
                       rsp.adjusted_count, rsp.probability, rsp.not_finalized});
  end

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 4_000_000) begin
      $display("[positional_bigram_markov_stats] ERROR");
      $finish;
    end
  end

  task automatic send(action_t act, logic [7:0] ch = 8'd0, logic [3:0] pos = 4'd0,
                      logic [7:0] prv = 8'd0, logic [7:0] nxt = 8'd0);
    while (!quiet && $urandom_range(99) < 27) begin
      req.valid = 0;
      @(negedge clk);
    end
    req.valid = 1; req.action = act; req.char_code = ch;
    req.position = pos; req.prev_code = prv; req.next_code = nxt;
    do @(posedge clk); while (!req.ready);
    sb.note_input(act, ch, pos, prv, nxt);
    if (act == ACT_CHAR) recent.push_back(ch);
    if (recent.size() > 32) void'(recent.pop_front());
    @(negedge clk);
    req.valid = 0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [4:0] val);
    drain();
    cfg.valid = 1; cfg.index = idx; cfg.data = val;
    do @(posedge clk); while (!cfg.ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(99) < 70) return 8'h61 + 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_line(int len);
    for (int i = 0; i < len; i++) send(ACT_CHAR, rand_char());
    send(ACT_EOL);
  endtask

  task automatic random_read();
    logic [7:0] pr, nx;
    if (recent.size() > 1 && $urandom_range(1)) begin
      pr = recent[$urandom_range(recent.size() - 1)];
      nx = recent[$urandom_range(recent.size() - 1)];
    end else begin
      pr = 8'($urandom_range(255));
      nx = 8'($urandom_range(255));
    end
    if ($urandom_range(3) == 0) pr = 8'd0;
    send(ACT_READ, 8'd0, 4'($urandom_range(15)), pr, nx);
  endtask

  int unsigned min_set[6] = '{1, 3, 16, 10, 1, 2};
  int unsigned max_set[6] = '{16, 5, 16, 2, 1, 12};
  int len;

  initial begin
    hold_request = 0; stall_left = 0; idle_cycles = 0; quiet = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    write_reg(REG_MIN_LENGTH, 5'd1);
    write_reg(REG_MAX_LENGTH, 5'd16);

    // directed: single byte, empty line, extremes, long line, full line
    send(ACT_CHAR, 8'h00); send(ACT_EOL);
    send(ACT_EOL);
    send(ACT_CHAR, 8'hFF); send(ACT_CHAR, 8'h00); send(ACT_CHAR, 8'hFF); send(ACT_EOL);
    for (int i = 0; i < 17; i++) send(ACT_CHAR, 8'(i * 15));
    send(ACT_EOL);
    for (int i = 0; i < 16; i++) send(ACT_CHAR, (i % 2) ? 8'hAA : 8'h55);
    send(ACT_EOL);
    send(ACT_READ, 8'd0, 4'd0, 8'h00, 8'h00);
    send(ACT_READ, 8'd0, 4'd15, 8'hFF, 8'hFF);
    send(ACT_READ, 8'd0, 4'd14, 8'h55, 8'hAA);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MIN_LENGTH, 5'(min_set[ph]));
      write_reg(REG_MAX_LENGTH, 5'(max_set[ph]));
      quiet = (ph == 2);
      if (ph == 1) hold_request = 400;
      for (int n = 0; n < 125; ) begin
        case ($urandom_range(19))
          0:       len = 0;
          1:       len = 17 + $urandom_range(3);
          2, 3:    len = 16;
          default: len = 1 + $urandom_range(15);
        endcase
        if (max_set[ph] < 8 && $urandom_range(1)) len = 1 + $urandom_range(max_set[ph]);
        send_line(len);
        n += len + 1;
        if ($urandom_range(3) == 0) begin
          random_read();
          n++;
        end
      end
    end
    quiet = 0;
    write_reg(REG_MIN_LENGTH, 5'd1);
    write_reg(REG_MAX_LENGTH, 5'd16);

    send(ACT_FINAL);
    for (int i = 0; i < 80; i++) random_read();
    send(ACT_READ, 8'd0, 4'd0, 8'h00, 8'h00);
    send(ACT_READ, 8'd0, 4'd15, 8'hFF, 8'h00);
    send(ACT_FINAL);
    send_line(3);
    hold_request = 200;
    for (int i = 0; i < 40; i++) random_read();

    drain();
    if (sb.errors == 0) $display("[positional_bigram_markov_stats] OK");
    else $display("[positional_bigram_markov_stats] ERROR");
    $finish;
  end
endmodule
